// File: sv/cll_pkg.sv
`timescale 1ns / 1ps

package cll_pkg;

  localparam int CODE_BITS  = 4;
  localparam int MS_BITS    = 16;
  localparam int LIMIT_BITS = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [MS_BITS-1:0]    BLINK_ON_RST  = 16'd200;
  localparam logic [MS_BITS-1:0]    BLINK_OFF_RST = 16'd200;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RST     = 4'd3;
  localparam logic [LIMIT_BITS-1:0] COUNT_MAX     = 4'hF;
  localparam logic [MS_BITS-1:0]    TIMER_MAX     = 16'hFFFF;

  // register map of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_ON  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_OFF = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAIL_LIM  = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLOSED      = 2'd0,
    MODE_OPENED      = 2'd1,
    MODE_PROGRAMMING = 2'd2,
    MODE_ALARM       = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code_switches;
    logic                 read_switch;
    logic                 program_switch;
    logic                 ms_tick;
  } in_word_t;

  typedef struct packed {
    logic       led_opened;
    logic       led_alarm;
    logic       led_programming;
    logic [1:0] lock_mode;
  } out_word_t;

  typedef struct packed {
    logic [MS_BITS-1:0]    blink_on_ms;
    logic [MS_BITS-1:0]    blink_off_ms;
    logic [LIMIT_BITS-1:0] failure_limit;
  } cfg_t;

  // what the lock FSM reports for the word being stepped
  typedef struct packed {
    mode_t start_mode;
    mode_t next_mode;
    logic  led_opened;
    logic  led_programming;
  } fsm_stat_t;

endpackage

// File: sv/code_lock_controller.sv
`timescale 1ns / 1ps

// Code lock controller. Each input word is one switch sample (4-bit code,
// read switch, program switch, millisecond tick); each produces exactly one
// output word with the three LEDs and the mode after the step. A word is
// registered on entry, stepped through the lock state machine and blink
// timer once the output register is free or being drained, and the result
// is held in an output register, so the block takes one word per clock
// unless a full output register stalls. in_ready drops only while the output
// register is full and unread and the input register holds a word. Blink
// times are counted in ms_tick samples, not clocks. Alarm is terminal: only
// reset leaves it. Configuration registers (0 blink on, 1 blink off,
// 2 failure limit) are written through the cfg_ port, which is always ready;
// write them only while no word is in flight.
module code_lock_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cll_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cll_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cll_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cll_pkg::MS_BITS-1:0]       cfg_data
);

  cll_pkg::cfg_t      cfg;
  cll_pkg::fsm_stat_t stat;
  cll_pkg::in_word_t  in_word_r;
  cll_pkg::out_word_t out_word_r, out_word_nxt;
  logic in_valid_r, out_valid_r;
  logic step_en, in_take, led_alarm_nxt;

  // step the stored word when the output register is free or being drained
  assign step_en   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_en;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  cll_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cll_lock_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .word          (in_word_r),
    .failure_limit (cfg.failure_limit),
    .stat          (stat)
  );

  cll_blink u_blink (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .ms_tick       (in_word_r.ms_tick),
    .in_alarm      (stat.start_mode == cll_pkg::MODE_ALARM),
    .cfg           (cfg),
    .led_alarm_nxt (led_alarm_nxt)
  );

  always_comb begin
    out_word_nxt.led_opened      = stat.led_opened;
    out_word_nxt.led_alarm       = led_alarm_nxt;
    out_word_nxt.led_programming = stat.led_programming;
    out_word_nxt.lock_mode       = stat.next_mode;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
    if (step_en) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef SYNTH
  // alarm is terminal
  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.start_mode == cll_pkg::MODE_ALARM) |=> (stat.start_mode == cll_pkg::MODE_ALARM))
    else $error("lock left alarm mode");

  // the programming LED is never lit without the opened LED
  a_led_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_word_r.led_programming || out_word_r.led_opened))
    else $error("programming LED without opened LED");

  // state only moves when a word is stepped
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(stat.start_mode))
    else $error("mode changed without a step");

  // an empty input register never stalls the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled while input register empty");
`endif

endmodule

// File: sv/cll_cfg_regs.sv
`timescale 1ns / 1ps

module cll_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [cll_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [cll_pkg::MS_BITS-1:0]       wr_data,
  output cll_pkg::cfg_t                     cfg
);

  cll_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        cll_pkg::REG_BLINK_ON:  cfg_nxt.blink_on_ms   = wr_data;
        cll_pkg::REG_BLINK_OFF: cfg_nxt.blink_off_ms  = wr_data;
        cll_pkg::REG_FAIL_LIM:  cfg_nxt.failure_limit = wr_data[cll_pkg::LIMIT_BITS-1:0];
        default:                cfg_nxt = cfg_r; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_on_ms   <= cll_pkg::BLINK_ON_RST;
      cfg_r.blink_off_ms  <= cll_pkg::BLINK_OFF_RST;
      cfg_r.failure_limit <= cll_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/cll_lock_fsm.sv
`timescale 1ns / 1ps

module cll_lock_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  cll_pkg::in_word_t               word,
  input  logic [cll_pkg::LIMIT_BITS-1:0]  failure_limit,
  output cll_pkg::fsm_stat_t              stat
);

  cll_pkg::mode_t mode_r, mode_nxt;
  logic [cll_pkg::CODE_BITS-1:0]  stored_code_r, stored_code_nxt;
  logic [cll_pkg::CODE_BITS-1:0]  pending_code_r, pending_code_nxt;
  logic [cll_pkg::LIMIT_BITS-1:0] fail_cnt_r, fail_cnt_nxt;
  logic prev_read_r, prev_prog_r;

  logic read_rise, read_fall, prog_rise, prog_fall, code_match;

  assign read_rise  = word.read_switch & ~prev_read_r;
  assign read_fall  = ~word.read_switch & prev_read_r;
  assign prog_rise  = word.program_switch & ~prev_prog_r;
  assign prog_fall  = ~word.program_switch & prev_prog_r;
  assign code_match = (word.code_switches == stored_code_r);

  // code store and failure counter
  always_comb begin
    stored_code_nxt  = stored_code_r;
    pending_code_nxt = pending_code_r;
    fail_cnt_nxt     = fail_cnt_r;
    case (mode_r)
      cll_pkg::MODE_CLOSED: begin
        if (read_rise) begin
          if (code_match) begin
            fail_cnt_nxt = '0;
          end else if (fail_cnt_r != cll_pkg::COUNT_MAX) begin
            fail_cnt_nxt = fail_cnt_r + 1'b1;
          end
        end
      end
      cll_pkg::MODE_PROGRAMMING: begin
        if (read_rise) begin
          pending_code_nxt = word.code_switches;
        end
        if (prog_fall && (pending_code_nxt != stored_code_r)) begin
          stored_code_nxt = pending_code_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      cll_pkg::MODE_CLOSED: begin
        if (read_rise && code_match) begin
          mode_nxt = cll_pkg::MODE_OPENED;
        end
        // checked on every closed step, after the code check
        if (fail_cnt_nxt >= failure_limit) begin
          mode_nxt = cll_pkg::MODE_ALARM;
        end
      end
      cll_pkg::MODE_OPENED: begin
        if (read_fall) begin
          mode_nxt = cll_pkg::MODE_CLOSED;
        end else if (prog_rise) begin
          mode_nxt = cll_pkg::MODE_PROGRAMMING;
        end
      end
      cll_pkg::MODE_PROGRAMMING: begin
        if (prog_fall && (pending_code_nxt != stored_code_r)) begin
          mode_nxt = cll_pkg::MODE_CLOSED;
        end
      end
      default: mode_nxt = cll_pkg::MODE_ALARM;
    endcase
  end

  // outputs, from the mode at the start of the step
  always_comb begin
    stat.start_mode      = mode_r;
    stat.next_mode       = mode_nxt;
    stat.led_opened      = 1'b0;
    stat.led_programming = 1'b0;
    case (mode_r)
      cll_pkg::MODE_OPENED:      stat.led_opened = 1'b1;
      cll_pkg::MODE_PROGRAMMING: begin
        stat.led_opened      = 1'b1;
        stat.led_programming = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= cll_pkg::MODE_CLOSED;
      stored_code_r  <= '0;
      pending_code_r <= '0;
      fail_cnt_r     <= '0;
      prev_read_r    <= 1'b0;
      prev_prog_r    <= 1'b0;
    end else if (step_en) begin
      mode_r         <= mode_nxt;
      stored_code_r  <= stored_code_nxt;
      pending_code_r <= pending_code_nxt;
      fail_cnt_r     <= fail_cnt_nxt;
      prev_read_r    <= word.read_switch;
      prev_prog_r    <= word.program_switch;
    end
  end

endmodule

// File: sv/cll_blink.sv
`timescale 1ns / 1ps

module cll_blink (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           ms_tick,
  input  logic           in_alarm,
  input  cll_pkg::cfg_t  cfg,
  output logic           led_alarm_nxt
);

  logic [cll_pkg::MS_BITS-1:0] timer_r, timer_nxt;
  logic [cll_pkg::MS_BITS:0]   period;
  logic alarm_led_r, timer_clr;

  assign period    = {1'b0, cfg.blink_on_ms} + {1'b0, cfg.blink_off_ms};
  assign timer_clr = in_alarm && ({1'b0, timer_r} >= period);

  always_comb begin
    led_alarm_nxt = alarm_led_r;
    if (in_alarm) begin
      led_alarm_nxt = (timer_r < cfg.blink_on_ms);
    end
    if (timer_clr) begin
      timer_nxt = '0;
    end else if (ms_tick && (timer_r != cll_pkg::TIMER_MAX)) begin
      timer_nxt = timer_r + 1'b1;
    end else begin
      timer_nxt = timer_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r     <= '0;
      alarm_led_r <= 1'b0;
    end else if (step_en) begin
      timer_r     <= timer_nxt;
      alarm_led_r <= led_alarm_nxt;
    end
  end

endmodule

// File: tb/sv/code_lock_checker.sv
`timescale 1ns / 1ps

module code_lock_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  cll_pkg::in_word_t                 in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  cll_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cll_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cll_pkg::MS_BITS-1:0]       cfg_data,
  output int                                status_backlog,
  output int                                mismatch_count
);

  import cll_pkg::*;

  // register copy
  logic [MS_BITS-1:0]    on_ms;
  logic [MS_BITS-1:0]    off_ms;
  logic [LIMIT_BITS-1:0] fail_limit;

  // lock state copy
  mode_t                 lock_state;
  logic [CODE_BITS-1:0]  stored_code;
  logic [CODE_BITS-1:0]  pending_code;
  logic [LIMIT_BITS-1:0] miss_count;
  logic                  prev_read;
  logic                  prev_prog;
  logic [MS_BITS-1:0]    blink_timer;
  logic                  alarm_lamp;

  out_word_t predicted_status[$];
  int        errors = 0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic out_word_t step_lock(in_word_t w);
    out_word_t   r;
    mode_t       start;
    logic        rd_rise;
    logic        rd_fall;
    logic        pg_rise;
    logic        pg_fall;
    logic        clear_timer;
    logic [16:0] blink_span;
    rd_rise     = w.read_switch && !prev_read;
    rd_fall     = !w.read_switch && prev_read;
    pg_rise     = w.program_switch && !prev_prog;
    pg_fall     = !w.program_switch && prev_prog;
    start       = lock_state;
    clear_timer = 1'b0;
    blink_span  = {1'b0, on_ms} + {1'b0, off_ms};
    case (start)
      MODE_CLOSED: begin
        if (rd_rise) begin
          if (w.code_switches == stored_code) begin
            lock_state = MODE_OPENED;
            miss_count = '0;
          end else if (miss_count != COUNT_MAX) begin
            miss_count = miss_count + 1'b1;
          end
        end
        // limit test runs on every closed step
        if (miss_count >= fail_limit) lock_state = MODE_ALARM;
      end
      MODE_OPENED: begin
        if (rd_fall) lock_state = MODE_CLOSED;
        else if (pg_rise) lock_state = MODE_PROGRAMMING;
      end
      MODE_PROGRAMMING: begin
        if (rd_rise) pending_code = w.code_switches;
        if (pg_fall && pending_code != stored_code) begin
          stored_code = pending_code;
          lock_state  = MODE_CLOSED;
        end
      end
      default: begin
        alarm_lamp = (blink_timer < on_ms);
        if ({1'b0, blink_timer} >= blink_span) clear_timer = 1'b1;
      end
    endcase
    if (clear_timer) blink_timer = '0;
    else if (w.ms_tick && blink_timer != TIMER_MAX) blink_timer = blink_timer + 1'b1;
    prev_read = w.read_switch;
    prev_prog = w.program_switch;
    r.led_opened      = (start == MODE_OPENED) || (start == MODE_PROGRAMMING);
    r.led_alarm       = alarm_lamp;
    r.led_programming = (start == MODE_PROGRAMMING);
    r.lock_mode       = lock_state;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      on_ms        = BLINK_ON_RST;
      off_ms       = BLINK_OFF_RST;
      fail_limit   = LIMIT_RST;
      lock_state   = MODE_CLOSED;
      stored_code  = '0;
      pending_code = '0;
      miss_count   = '0;
      prev_read    = 1'b0;
      prev_prog    = 1'b0;
      blink_timer  = '0;
      alarm_lamp   = 1'b0;
      predicted_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          $error("unexpected output word %h", out_data);
          errors++;
        end else begin
          want = predicted_status.pop_front();
          check_field("led_opened", want.led_opened, out_data.led_opened);
          check_field("led_alarm", want.led_alarm, out_data.led_alarm);
          check_field("led_programming", want.led_programming, out_data.led_programming);
          check_field("lock_mode", want.lock_mode, out_data.lock_mode);
        end
      end
      if (in_valid && in_ready) predicted_status.push_back(step_lock(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLINK_ON:  on_ms = cfg_data;
          REG_BLINK_OFF: off_ms = cfg_data;
          REG_FAIL_LIM:  fail_limit = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
    end
    status_backlog <= predicted_status.size();
    mismatch_count <= errors;
  end

endmodule

// File: tb/sv/code_lock_controller_test.sv
`timescale 1ns / 1ps

module code_lock_controller_test;

  import cll_pkg::*;

  // generous bound: about a thousand words stay far inside it
  // even under the heaviest stalls
  localparam int CYCLE_LIMIT = 100_000;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH
  } flow_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  in_word_t                in_data   = '0;
  logic                    out_ready = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [MS_BITS-1:0]      cfg_data  = '0;
  logic                    in_ready;
  logic                    out_valid;
  out_word_t               out_data;
  logic                    cfg_ready;

  int status_backlog;
  int mismatch_count;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int words_sent   = 0;

  // what the stimulus believes the stored code and limit are; only used to
  // shape well-formed sequences, never to check anything
  logic [CODE_BITS-1:0]  known_code = '0;
  logic [LIMIT_BITS-1:0] fail_lim   = LIMIT_RST;

  code_lock_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  code_lock_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .status_backlog (status_backlog),
    .mismatch_count (mismatch_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [CODE_BITS-1:0] any_code();
    return CODE_BITS'($urandom_range(15));
  endfunction

  // any code other than the stored one
  function automatic logic [CODE_BITS-1:0] other_code();
    return known_code ^ CODE_BITS'($urandom_range(1, 15));
  endfunction

  function automatic in_word_t sample(logic [CODE_BITS-1:0] code, logic rd, logic pg,
                                      logic tick);
    in_word_t w;
    w.code_switches  = code;
    w.read_switch    = rd;
    w.program_switch = pg;
    w.ms_tick        = tick;
    return w;
  endfunction

  task automatic set_flow(flow_t f);
    case (f)
      FLOW_SENDER_IDLE: begin
        tx_idle_pct  = 69;
        rx_stall_pct = 0;
      end
      FLOW_RECEIVER_STALL: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 69;
      end
      FLOW_BOTH: begin
        tx_idle_pct  = 32;
        rx_stall_pct = 32;
      end
      default: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
    endcase
  endtask

  // Offer one word. Valid is only dropped for an idle gap, so back-to-back
  // words keep it high with a single assignment per edge.
  task automatic push_sample(in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_backlog != 0);
  endtask

  // all three registers in one burst; valid stays up between writes
  task automatic program_regs(logic [MS_BITS-1:0] on_ms, logic [MS_BITS-1:0] off_ms,
                              logic [LIMIT_BITS-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BLINK_ON;
    cfg_data  <= on_ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BLINK_OFF;
    cfg_data  <= off_ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FAIL_LIM;
    cfg_data  <= MS_BITS'(limit);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fail_lim = limit;
  endtask

  // Read low first (closes the lock if something left it open), a few wrong
  // tries kept under the limit, then the right code.
  task automatic open_lock();
    int misses;
    misses = $urandom_range((fail_lim > 3) ? 3 : fail_lim - 1);
    push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    repeat (misses) begin
      push_sample(sample(other_code(), 1'b1, 1'b0, coin()));
      push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    end
    push_sample(sample(known_code, 1'b1, 1'b0, coin()));
  endtask

  task automatic close_lock();
    if (coin()) begin
      push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    end else begin
      // read falls and program rises together: the close must win
      push_sample(sample(any_code(), 1'b0, 1'b1, coin()));
      push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    end
  endtask

  // From opened: enter programming, latch a fresh code and store it.
  // Now and then the stored code is offered first and must be refused.
  task automatic reprogram();
    logic [CODE_BITS-1:0] fresh;
    fresh = other_code();
    push_sample(sample(any_code(), 1'b1, 1'b1, coin()));
    push_sample(sample(any_code(), 1'b0, 1'b1, coin()));
    if ($urandom_range(3) == 0) begin
      push_sample(sample(known_code, 1'b1, 1'b0, coin()));
      push_sample(sample(any_code(), 1'b0, 1'b1, coin()));
    end
    if (coin()) begin
      // latch and store on the same word
      push_sample(sample(fresh, 1'b1, 1'b0, coin()));
    end else begin
      push_sample(sample(fresh, 1'b1, 1'b1, coin()));
      push_sample(sample(any_code(), 1'b1, 1'b0, coin()));
    end
    known_code = fresh;
  endtask

  // Loose switch noise with the program switch held low, so it can never
  // change the stored code. At most two read rises per burst.
  task automatic scramble(int n_words);
    repeat (n_words) push_sample(sample(any_code(), coin(), 1'b0, coin()));
  endtask

  // Mostly full open/close/reprogram sequences, a little noise where the
  // limit leaves room for stray failures. Flow control rotates every 40 words.
  task automatic run_traffic(int n_words);
    int stop_at;
    int pick;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      set_flow(flow_t'(((stop_at - words_sent) / 40) % 4));
      pick = $urandom_range(9);
      open_lock();
      if (pick < 4) begin
        close_lock();
      end else if (pick < 8) begin
        reprogram();
      end else begin
        close_lock();
        if (fail_lim >= 8) scramble($urandom_range(1, 3));
      end
    end
  endtask

  // In alarm nothing matters but the blink timer, so every field is free.
  task automatic alarm_traffic(int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      set_flow(flow_t'(((stop_at - words_sent) / 25) % 4));
      push_sample(sample(any_code(), coin(), coin(), coin()));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening, reset registers, stored code zero
    set_flow(FLOW_FREE);
    push_sample(sample(4'd0,  1'b0, 1'b0, 1'b0));
    push_sample(sample(4'd15, 1'b1, 1'b0, 1'b1));   // wrong code, one failure
    push_sample(sample(4'd0,  1'b0, 1'b0, 1'b0));
    push_sample(sample(4'd0,  1'b1, 1'b0, 1'b1));   // opens, count cleared
    push_sample(sample(4'd9,  1'b0, 1'b1, 1'b1));   // read fall beats prog rise
    push_sample(sample(4'd0,  1'b1, 1'b1, 1'b0));   // reopen, program already high
    push_sample(sample(4'd6,  1'b1, 1'b0, 1'b1));   // prog fall ignored when open
    push_sample(sample(4'd0,  1'b1, 1'b1, 1'b1));   // programming
    push_sample(sample(4'd3,  1'b0, 1'b1, 1'b0));
    push_sample(sample(4'd0,  1'b1, 1'b0, 1'b1));   // same code: refused
    push_sample(sample(4'd5,  1'b0, 1'b1, 1'b0));
    push_sample(sample(4'd15, 1'b1, 1'b0, 1'b1));   // latch and store together
    push_sample(sample(4'd15, 1'b0, 1'b0, 1'b1));
    push_sample(sample(4'd15, 1'b1, 1'b0, 1'b1));   // opens with the new code
    known_code = 4'd15;
    close_lock();

    run_traffic(120);

    // register sweeps, extremes included; each waits for the pipe to empty
    settle();
    program_regs(16'd0, 16'hFFFF, 4'd1);
    run_traffic(170);

    settle();
    program_regs(16'hFFFF, 16'd0, 4'd15);
    run_traffic(170);

    settle();
    program_regs(MS_BITS'($urandom_range(1, 50)), MS_BITS'($urandom_range(1, 50)),
                 LIMIT_BITS'($urandom_range(8, 14)));
    run_traffic(170);

    // drive into alarm: fifteen wrong tries with the limit at its top
    settle();
    program_regs(16'd3, 16'd2, 4'd15);
    set_flow(FLOW_FREE);
    push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    repeat (15) begin
      push_sample(sample(other_code(), 1'b1, 1'b0, coin()));
      push_sample(sample(any_code(), 1'b0, 1'b0, coin()));
    end
    alarm_traffic(150);

    // zero on and off times: timer cleared on every alarm word
    settle();
    program_regs(16'd0, 16'd0, 4'd15);
    alarm_traffic(30);

    // span of 65536 must not wrap to zero and clear the timer every word
    settle();
    program_regs(16'hFFFF, 16'd1, 4'd15);
    alarm_traffic(20);

    // span of 65535, the largest that fits in 16 bits
    settle();
    program_regs(16'hFFFF, 16'd0, 4'd15);
    alarm_traffic(20);

    settle();
    program_regs(MS_BITS'($urandom_range(0, 6)), MS_BITS'($urandom_range(0, 6)), 4'd1);
    alarm_traffic(120);

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: code_lock_controller.f
sv/cll_pkg.sv
sv/cll_cfg_regs.sv
sv/cll_lock_fsm.sv
sv/cll_blink.sv
sv/code_lock_controller.sv
tb/sv/code_lock_checker.sv
tb/sv/code_lock_controller_test.sv
